[rtl/tfp_pkg.sv]
// Shared types, constants and the escape table for the five-bit text packer.
// No dependencies; all other files but the queue import this package.
package tfp_pkg;

  // Code values and byte boundaries
  localparam logic [4:0] ESC_CODE     = 5'h1E;
  localparam logic [7:0] SPACE_BYTE   = 8'h20;
  localparam logic [7:0] LOWER_FIRST  = 8'h61;
  localparam logic [7:0] LOWER_OFFSET = 8'h60;

  // Request codes on the input channel
  localparam logic REQ_TEXT  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // Bytes that encode as escape plus their position in this table
  localparam int TABLE_LEN = 23;
  localparam logic [7:0] ESC_TABLE [TABLE_LEN] = '{
    8'h00, 8'h09, 8'h0a, 8'h21, 8'h22, 8'h28, 8'h29, 8'h2c,
    8'h2d, 8'h2e, 8'h2f, 8'h3a, 8'h43, 8'h46, 8'h47, 8'h48,
    8'h49, 8'h53, 8'h54, 8'h59, 8'h5b, 8'h5d, 8'h5f
  };

  // Default queue depths
  localparam int DEF_QUEUE_DEPTH  = 2;
  localparam int DEF_RESULT_DEPTH = 2;

  // Classified request passed from front to back
  typedef enum logic [1:0] {
    K_CODE  = 2'd0,
    K_ESC   = 2'd1,
    K_FLUSH = 2'd2,
    K_BAD   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [4:0] code;
  } rec_t;

  // One result item
  typedef struct packed {
    logic [14:0] word;
    logic        valid;
    logic        eom;
    logic        bad;
  } res_t;

endpackage

[rtl/tfp_fifo.sv]
// Small register-based queue used between the packer's stages and at its output.
// Generic in entry type and depth; depends on nothing else.
module tfp_fifo #(
  parameter type ENTRY_T = logic,
  parameter int  DEPTH   = 2
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  output logic   full,
  input  ENTRY_T data_in,
  input  logic   pop,
  output logic   empty,
  output ENTRY_T data_out
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ENTRY_T          mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            wr, rd;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign wr       = push && !full;
  assign rd       = pop && !empty;
  assign data_out = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the depth, track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr && !rd) begin
      count_nxt = count_r + 1'b1;
    end else if (rd && !wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= data_in;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue fill level above depth");

  a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (wr && !rd) |=> (count_r == CW'($past(count_r) + 1'b1)))
    else $error("queue write without read did not raise fill level");

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(full && empty))
    else $error("queue reports full and empty at once");
`endif

endmodule

[rtl/tfp_front.sv]
// Front stage: accepts requests and classifies each byte into a code,
// an escape index, a flush or an error. Depends on tfp_pkg.
module tfp_front (
  input  logic          in_push,
  output logic          in_full,
  input  logic          in_req_type,
  input  logic [7:0]    in_char_byte,
  output logic          q_push,
  input  logic          q_full,
  output tfp_pkg::rec_t q_rec
);
  import tfp_pkg::*;

  logic       hit;
  logic [4:0] idx;
  logic [7:0] lower_code;

  assign in_full    = q_full;
  assign q_push     = in_push && !q_full;
  assign lower_code = in_char_byte - LOWER_OFFSET;

  // Match against the escape table in parallel
  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int i = 0; i < TABLE_LEN; i++) begin
      if (in_char_byte == ESC_TABLE[i]) begin
        hit = 1'b1;
        idx = 5'(i);
      end
    end
  end

  // Classify the request
  always_comb begin
    q_rec.kind = K_BAD;
    q_rec.code = '0;
    if (in_req_type == REQ_FLUSH) begin
      q_rec.kind = K_FLUSH;
    end else if (in_char_byte == SPACE_BYTE) begin
      q_rec.kind = K_CODE;
    end else if (in_char_byte >= LOWER_FIRST && !in_char_byte[7]) begin
      q_rec.kind = K_CODE;
      q_rec.code = lower_code[4:0];
    end else if (hit) begin
      q_rec.kind = K_ESC;
      q_rec.code = idx;
    end
  end

endmodule

[rtl/tfp_back.sv]
// Back stage: packs codes three to a word, handles flush and the sticky
// error flag, and writes result items. Depends on tfp_pkg.
module tfp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rec_empty,
  output logic          rec_pop,
  input  tfp_pkg::rec_t rec,
  input  logic          res_full,
  output logic          res_push,
  output tfp_pkg::res_t res
);
  import tfp_pkg::*;

  // Only the two newest codes are ever pending
  logic [9:0] acc_r, acc_nxt;
  logic [1:0] held_r, held_nxt;
  logic       err_r, err_nxt;
  logic       emit;

  assign rec_pop  = !rec_empty && !res_full;
  assign res_push = rec_pop && emit;

  // Pack one classified request
  always_comb begin
    acc_nxt   = acc_r;
    held_nxt  = held_r;
    err_nxt   = err_r;
    emit      = 1'b0;
    res.word  = '0;
    res.valid = 1'b0;
    res.eom   = 1'b0;
    unique case (rec.kind)
      K_FLUSH: begin
        emit     = 1'b1;
        res.eom  = 1'b1;
        acc_nxt  = '0;
        held_nxt = '0;
        if (held_r == 2'd1) begin
          res.valid = 1'b1;
          res.word  = {acc_r[4:0], 10'd0};
        end else if (held_r == 2'd2) begin
          res.valid = 1'b1;
          res.word  = {acc_r, 5'd0};
        end
      end
      K_CODE: begin
        if (held_r == 2'd2) begin
          emit      = 1'b1;
          res.valid = 1'b1;
          res.word  = {acc_r, rec.code};
          acc_nxt   = '0;
          held_nxt  = '0;
        end else begin
          acc_nxt  = {acc_r[4:0], rec.code};
          held_nxt = held_r + 1'b1;
        end
      end
      K_ESC: begin
        if (held_r == 2'd0) begin
          acc_nxt  = {ESC_CODE, rec.code};
          held_nxt = 2'd2;
        end else if (held_r == 2'd1) begin
          emit      = 1'b1;
          res.valid = 1'b1;
          res.word  = {acc_r[4:0], ESC_CODE, rec.code};
          acc_nxt   = '0;
          held_nxt  = '0;
        end else begin
          // Escape finishes this word, index opens the next
          emit      = 1'b1;
          res.valid = 1'b1;
          res.word  = {acc_r, ESC_CODE};
          acc_nxt   = {5'd0, rec.code};
          held_nxt  = 2'd1;
        end
      end
      K_BAD: begin
        emit    = 1'b1;
        err_nxt = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    res.bad = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      held_r <= '0;
      err_r  <= 1'b0;
    end else if (rec_pop) begin
      acc_r  <= acc_nxt;
      held_r <= held_nxt;
      err_r  <= err_nxt;
    end
  end

`ifndef SYNTH
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r != 2'd3)
    else $error("more than two codes pending");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (rec_pop && rec.kind == K_FLUSH) |=> (held_r == 2'd0 && acc_r == '0))
    else $error("flush left codes pending");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |=> err_r)
    else $error("error flag cleared without reset");
`endif

endmodule

[rtl/text_five_bit_packer.sv]
// Five-bit text packer: turns text bytes into 5-bit codes, three to a word.
// Path: a request is registered in the request queue, then the back stage
// packs it and any result is registered in the result queue for out_ ports.
// Throughput: one request per cycle while in_full is low; in_full rises only when the result
// queue backs up through the request queue.
// Reset (synchronous, rst_n low): empties both queues, drops pending codes
// and clears the error flag.
module text_five_bit_packer #(
  parameter int QUEUE_DEPTH  = tfp_pkg::DEF_QUEUE_DEPTH,
  parameter int RESULT_DEPTH = tfp_pkg::DEF_RESULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_req_type,
  input  logic [7:0]  in_char_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [14:0] out_packed_word,
  output logic        out_word_valid,
  output logic        out_end_of_message,
  output logic        out_bad_char
);
  import tfp_pkg::*;

  logic q_push, q_full, q_empty, q_pop;
  rec_t q_wr_rec, q_rd_rec;
  logic res_push, res_full;
  res_t res_wr, res_rd;

  // Classify incoming requests
  tfp_front u_front (
    .in_push      (in_push),
    .in_full      (in_full),
    .in_req_type  (in_req_type),
    .in_char_byte (in_char_byte),
    .q_push       (q_push),
    .q_full       (q_full),
    .q_rec        (q_wr_rec)
  );

  // Decouple front from back
  tfp_fifo #(.ENTRY_T(rec_t), .DEPTH(QUEUE_DEPTH)) u_req_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .full     (q_full),
    .data_in  (q_wr_rec),
    .pop      (q_pop),
    .empty    (q_empty),
    .data_out (q_rd_rec)
  );

  // Pack codes into words
  tfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_empty (q_empty),
    .rec_pop   (q_pop),
    .rec       (q_rd_rec),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_wr)
  );

  // Hold results until taken
  tfp_fifo #(.ENTRY_T(res_t), .DEPTH(RESULT_DEPTH)) u_res_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .full     (res_full),
    .data_in  (res_wr),
    .pop      (out_pop),
    .empty    (out_empty),
    .data_out (res_rd)
  );

  assign out_packed_word    = res_rd.word;
  assign out_word_valid     = res_rd.valid;
  assign out_end_of_message = res_rd.eom;
  assign out_bad_char       = res_rd.bad;

endmodule
